// File: hw/rtl/assert_macros.svh
// shared assertion wrappers, all checks sampled on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/gfam_pkg.sv
`default_nettype none

package gfam_pkg;

    localparam int unsigned LANES = 8;

    localparam logic [7:0] GF_POLY_LOW = 8'h1b;

    typedef enum logic [1:0] {
        FUNC_MUL        = 2'd0,
        FUNC_AFFINE     = 2'd1,
        FUNC_AFFINE_INV = 2'd2
    } func_t;

    // fields the lanes need at the transform stage
    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] rows;
        logic [7:0]  imm;
    } lane_ctl_t;

    // shift-and-add multiply in GF(2^8), reduced by 0x11b
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = '0;
        aa  = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ aa;
            end
            aa = {aa[6:0], 1'b0} ^ (aa[7] ? GF_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    // squaring is linear over GF(2), synthesis folds it into xors
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        return gf_mul(a, a);
    endfunction

    // result bit n is parity of (row 7-n AND x) xor imm bit n
    function automatic logic [7:0] gf_affine(input logic [7:0] x, input logic [63:0] rows,
                                             input logic [7:0] c);
        logic [7:0] out;
        for (int n = 0; n < 8; n++) begin
            out[n] = (^(rows[8 * (7 - n) +: 8] & x)) ^ c[n];
        end
        return out;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gfam_lane.sv
`default_nettype none

module gfam_lane (
    input  logic                clk,
    input  logic                adv,
    input  logic [1:0]          func_in,
    input  logic [7:0]          x,
    input  logic [7:0]          b,
    input  gfam_pkg::lane_ctl_t ctl,
    output logic [7:0]          res
);
    import gfam_pkg::*;

    logic [7:0] src1_reg;
    logic [7:0] cube_reg;
    logic [7:0] sq_reg;
    logic [7:0] src2_reg;
    logic [7:0] pow15_reg;
    logic [7:0] pow14_reg;
    logic [7:0] src3_reg;
    logic [7:0] inv_reg;

    logic [7:0] src1_next;
    logic [7:0] pow12;

    // multiply mode carries the product, affine modes carry x itself
    always_comb
    begin
        if (func_t'(func_in) == FUNC_MUL)
        begin
            src1_next = gf_mul(x, b);
        end
        else
        begin
            src1_next = x;
        end
    end

    assign pow12 = gf_sq(gf_sq(cube_reg));

    // x^254 by chain x^3, x^12, x^15 and x^14, then x^240 * x^14
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            src1_reg  <= src1_next;
            cube_reg  <= gf_mul(gf_sq(x), x);
            sq_reg    <= gf_sq(x);
            src2_reg  <= src1_reg;
            pow15_reg <= gf_mul(pow12, cube_reg);
            pow14_reg <= gf_mul(pow12, sq_reg);
            src3_reg  <= src2_reg;
            inv_reg   <= gf_mul(gf_sq(gf_sq(gf_sq(gf_sq(pow15_reg)))), pow14_reg);
        end
    end

    always_comb
    begin
        unique case (func_t'(ctl.func))
            FUNC_MUL:        res = src3_reg;
            FUNC_AFFINE:     res = gf_affine(src3_reg, ctl.rows, ctl.imm);
            FUNC_AFFINE_INV: res = gf_affine(inv_reg, ctl.rows, ctl.imm);
            default:         res = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/gfam_merge.sv
`default_nettype none

module gfam_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s3_valid,
    input  logic [7:0][7:0]  lane_res,
    input  logic             rsp_stall,
    output logic             adv,
    output logic             rsp_valid,
    output logic [63:0]      result
);
    import gfam_pkg::*;

    logic        valid_reg;
    logic [63:0] result_reg;
    logic [63:0] result_next;

    // the whole pipe moves unless a finished result is held
    assign adv = !valid_reg || !rsp_stall;

    // lane i lands in byte i
    assign result_next = lane_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gf256_byte_mul_affine_unit.sv
`default_nettype none

// Galois-field byte unit for one 64-bit lane: byte multiply mod 0x11b, affine
// transform, or inverse followed by affine, on all eight bytes at once; an
// unused func gives zero. It takes one request every cycle while req_stall is
// low. Each request passes through the lane registers, which hold the three
// chained GF(2^8) multiplies of the x^254 inverse chain, and then the output
// register; all functions share the same depth so results stay in order. A
// result waiting under rsp_stall holds the whole pipeline and raises req_stall.

`include "assert_macros.svh"

module gf256_byte_mul_affine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  func,
    input  logic [63:0] operand_x,
    input  logic [63:0] operand_b,
    input  logic [7:0]  imm,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] result
);
    import gfam_pkg::*;

    logic            adv;
    logic            v1_reg;
    logic            v2_reg;
    logic            v3_reg;
    lane_ctl_t       ctl_next;
    lane_ctl_t       ctl1_reg;
    lane_ctl_t       ctl2_reg;
    lane_ctl_t       ctl3_reg;
    logic [7:0][7:0] lane_res;

    assign req_stall = !adv;

    always_comb
    begin
        ctl_next.func = func;
        ctl_next.rows = operand_b;
        ctl_next.imm  = imm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl1_reg <= ctl_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    for (genvar gi = 0; gi < LANES; gi++)
    begin : g_lane
        gfam_lane u_lane (
            .clk     (clk),
            .adv     (adv),
            .func_in (func),
            .x       (operand_x[8 * gi +: 8]),
            .b       (operand_b[8 * gi +: 8]),
            .ctl     (ctl3_reg),
            .res     (lane_res[gi])
        );
    end

    gfam_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .s3_valid  (v3_reg),
        .lane_res  (lane_res),
        .rsp_stall (rsp_stall),
        .adv       (adv),
        .rsp_valid (rsp_valid),
        .result    (result)
    );

    `ASSERT_NOW(a_stall_only_when_held, clk, rst_n, 1'b1, req_stall == (rsp_valid && rsp_stall))
    `ASSERT_NEXT(a_request_enters_pipe, clk, rst_n, req_valid && !req_stall, v1_reg)
    `ASSERT_NEXT(a_last_stage_reaches_output, clk, rst_n, v3_reg && adv, rsp_valid)
    `ASSERT_NEXT(a_unused_func_gives_zero, clk, rst_n, v3_reg && adv && ctl3_reg.func != FUNC_MUL && ctl3_reg.func != FUNC_AFFINE && ctl3_reg.func != FUNC_AFFINE_INV, result == '0)

endmodule

`default_nettype wire

// File: tb/sv/gf256_byte_mul_affine_unit_tb.sv
`timescale 1ns / 100ps

module gf256_byte_mul_affine_unit_tb;

    import gfam_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    localparam logic [8:0]  GF_POLY       = 9'h11b;
    localparam logic [63:0] ROWS_IDENTITY = 64'h0102040810204080;
    localparam logic [63:0] ROWS_SBOX     = 64'hF1E3C78F1F3E7CF8;
    localparam logic [7:0]  SBOX_CONST    = 8'h63;
    localparam int          PIPE_DEPTH    = 4;
    localparam int          QUIET_LIMIT   = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  func = FUNC_MUL;
    logic [63:0] operand_x = '0;
    logic [63:0] operand_b = '0;
    logic [7:0]  imm = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [63:0] result;

    logic [63:0] pending_results[$];
    logic [63:0] oldest_result;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          sender_bursts = 1'b0;
    bit          receiver_bursts = 1'b0;

    gf256_byte_mul_affine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .operand_x (operand_x),
        .operand_b (operand_b),
        .imm       (imm),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .result    (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // carry-less product, then fold bits 14..8 back with the field polynomial
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [14:0] wide;
        wide = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                wide = wide ^ (15'(a) << k);
            end
        end
        for (int k = 14; k >= 8; k--)
        begin
            if (wide[k])
            begin
                wide = wide ^ (15'(GF_POLY) << (k - 8));
            end
        end
        return wide[7:0];
    endfunction

    // search for the element whose product with a is one; zero stays zero
    function automatic logic [7:0] gf_inverse(input logic [7:0] a);
        logic [7:0] found;
        found = '0;
        for (int y = 1; y < 256; y++)
        begin
            if (gf_product(a, 8'(y)) == 8'h01)
            begin
                found = 8'(y);
            end
        end
        return found;
    endfunction

    // row j of the matrix drives output bit 7-j
    function automatic logic [7:0] affine_byte(input logic [7:0] a, input logic [63:0] rows,
                                               input logic [7:0] c);
        logic [7:0] out;
        out = c;
        for (int j = 0; j < 8; j++)
        begin
            out[7 - j] = out[7 - j] ^ (^(rows[8 * j +: 8] & a));
        end
        return out;
    endfunction

    function automatic logic [63:0] lane_result(input logic [1:0] f, input logic [63:0] x,
                                                input logic [63:0] b, input logic [7:0] c);
        logic [63:0] lane;
        lane = '0;
        for (int i = 0; i < 8; i++)
        begin
            case (f)
                FUNC_MUL:        lane[8 * i +: 8] = gf_product(x[8 * i +: 8], b[8 * i +: 8]);
                FUNC_AFFINE:     lane[8 * i +: 8] = affine_byte(x[8 * i +: 8], b, c);
                FUNC_AFFINE_INV: lane[8 * i +: 8] = affine_byte(gf_inverse(x[8 * i +: 8]), b, c);
                default:         lane[8 * i +: 8] = 8'h00;
            endcase
        end
        return lane;
    endfunction

    // bytes lean toward 0, 1, 0x80 and 0xff so the corner values show up often
    function automatic logic [63:0] random_lane();
        logic [63:0] lane;
        lane = {$urandom(), $urandom()};
        if ($urandom_range(0, 2) != 0)
        begin
            for (int i = 0; i < 8; i++)
            begin
                case ($urandom_range(0, 7))
                    0: lane[8 * i +: 8] = 8'h00;
                    1: lane[8 * i +: 8] = 8'h01;
                    2: lane[8 * i +: 8] = 8'h80;
                    3: lane[8 * i +: 8] = 8'hff;
                    default: ;
                endcase
            end
        end
        return lane;
    endfunction

    // request monitor, result checker and quiet-cycle counter
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (req_valid && !req_stall)
            begin
                pending_results.push_back(lane_result(func, operand_x, operand_b, imm));
                quiet_cycles = 0;
            end
            if (rsp_valid && !rsp_stall)
            begin
                quiet_cycles = 0;
                if (pending_results.size() == 0)
                begin
                    $error("result: expected none, actual %h", result);
                    fail_count++;
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (result !== oldest_result)
                    begin
                        $error("result: expected %h, actual %h", oldest_result, result);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result-side back-pressure in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0 && receiver_bursts && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11);
            end
            rsp_stall <= (stall_left != 0);
            if (stall_left != 0)
            begin
                stall_left--;
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("gf256_byte_mul_affine_unit verification failed");
        $finish;
    end

    task automatic send_request(input logic [1:0] f, input logic [63:0] x,
                                input logic [63:0] b, input logic [7:0] c);
        if (sender_bursts && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        operand_x <= x;
        operand_b <= b;
        imm       <= c;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
    endtask

    // hold off new requests until every outstanding result is back
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_byte_multiply();
        send_request(FUNC_MUL, 64'h0, 64'hffff_ffff_ffff_ffff, 8'h00);
        send_request(FUNC_MUL, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'h00);
        send_request(FUNC_MUL, 64'h5353_5353_5353_5353, 64'hcaca_caca_caca_caca, 8'h00);
        send_request(FUNC_MUL, 64'h8040_2010_0804_0201, 64'h8080_8080_8080_8080, 8'h00);
        send_request(FUNC_MUL, 64'h8080_8080_8080_8080, 64'h0202_0202_0202_0202, 8'h00);
        // imm must have no effect on a multiply
        send_request(FUNC_MUL, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 8'hff);
    endtask

    task automatic test_affine_transform();
        send_request(FUNC_AFFINE, {$urandom(), $urandom()}, ROWS_IDENTITY, 8'h00);
        send_request(FUNC_AFFINE, {$urandom(), $urandom()}, ROWS_IDENTITY, 8'hff);
        send_request(FUNC_AFFINE, {$urandom(), $urandom()}, 64'h0, 8'ha5);
        send_request(FUNC_AFFINE, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'h00);
        send_request(FUNC_AFFINE, {$urandom(), $urandom()}, ROWS_SBOX, SBOX_CONST);
    endtask

    task automatic test_inverse_affine();
        // zero source bytes come out as imm
        send_request(FUNC_AFFINE_INV, 64'h0, ROWS_IDENTITY, 8'h5a);
        send_request(FUNC_AFFINE_INV, 64'h0100_0100_53ca_0001, ROWS_SBOX, SBOX_CONST);
        send_request(FUNC_AFFINE_INV, 64'hffff_ffff_ffff_ffff, ROWS_SBOX, SBOX_CONST);
        send_request(FUNC_AFFINE_INV, {$urandom(), $urandom()}, ROWS_IDENTITY, 8'h00);
        send_request(FUNC_AFFINE_INV, 64'h8000_8000_8000_8000, {$urandom(), $urandom()},
                     8'($urandom()));
    endtask

    task automatic test_unused_selector();
        send_request(FUNC_UNUSED, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                     8'($urandom()));
        send_request(FUNC_UNUSED, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff);
    endtask

    task automatic test_random_traffic();
        logic [1:0]  f;
        logic [63:0] rows;
        int          pick;
        for (int seg = 0; seg < 14; seg++)
        begin
            // closing segments run without any idling
            sender_bursts   = (seg < 11) && ($urandom_range(0, 3) != 0);
            receiver_bursts = (seg < 11) && ($urandom_range(0, 3) != 0);
            if (seg == 6)
            begin
                wait_for_drain();
            end
            for (int n = 0; n < 50; n++)
            begin
                pick = $urandom_range(0, 15);
                case (pick % 3)
                    0:       f = FUNC_MUL;
                    1:       f = FUNC_AFFINE;
                    default: f = FUNC_AFFINE_INV;
                endcase
                if (pick == 15)
                begin
                    f = FUNC_UNUSED;
                end
                rows = random_lane();
                if ($urandom_range(0, 7) == 0)
                begin
                    rows = ROWS_SBOX;
                end
                send_request(f, random_lane(), rows, 8'($urandom()));
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_byte_multiply();
        test_affine_transform();
        test_inverse_affine();
        test_unused_selector();
        wait_for_drain();
        test_random_traffic();
        wait_for_drain();
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("result: %0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("gf256_byte_mul_affine_unit verification clean");
        end
        else
        begin
            $display("gf256_byte_mul_affine_unit verification failed");
        end
        $finish;
    end

endmodule
